@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must be followed in the same cycle by cons
`define HTBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// expr must never be true out of reset
`define HTBD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/htbd_pkg.sv @@
// Shared types and constants of the tree walk decoder.
package htbd_pkg;

    localparam int IDX_W           = 9;
    localparam int SYM_IN_W        = 8;
    localparam int SYM_OUT_W       = 8;
    localparam int NODE_COUNT_DEF  = 512;
    localparam int SYMBOL_BITS_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_BIT     = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_BIT,
        CMD_RESTART
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [IDX_W-1:0]      node_index;
        logic [IDX_W-1:0]      left_child;
        logic [IDX_W-1:0]      right_child;
        logic                  has_left;
        logic                  has_right;
        logic [SYM_IN_W-1:0]   leaf_symbol;
        logic                  coded_bit;
    } t_cmd_beat;

    typedef struct packed {
        logic      push;
        t_cmd_beat beat;
    } t_push;

    typedef struct packed {
        logic      valid;
        t_cmd_beat beat;
    } t_q_head;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CUR,
        B_NEXT
    } t_back_state;

endpackage

@@ rtl/htbd_front.sv @@
// Front end: accepts input beats, classifies them and drops those with no effect.
module htbd_front #(
    parameter int NODE_COUNT = htbd_pkg::NODE_COUNT_DEF
) (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_full,
    input  logic [1:0]                    i_operation,
    input  logic [htbd_pkg::IDX_W-1:0]    i_node_index,
    input  logic [htbd_pkg::IDX_W-1:0]    i_left_child,
    input  logic [htbd_pkg::IDX_W-1:0]    i_right_child,
    input  logic                          i_has_left,
    input  logic                          i_has_right,
    input  logic [htbd_pkg::SYM_IN_W-1:0] i_leaf_symbol,
    input  logic                          i_coded_bit,
    output htbd_pkg::t_push               o_push
);

    logic keep;
    htbd_pkg::t_cmd_kind kind;

    assign o_in_ready = !i_full;

    always_comb begin
        keep = 1'b0;
        kind = htbd_pkg::CMD_BIT;
        case (htbd_pkg::t_op'(i_operation))
            htbd_pkg::OP_WRITE: begin
                // writes beyond the table are swallowed here
                keep = (32'(i_node_index) < NODE_COUNT);
                kind = htbd_pkg::CMD_WRITE;
            end
            htbd_pkg::OP_BIT: begin
                keep = 1'b1;
                kind = htbd_pkg::CMD_BIT;
            end
            htbd_pkg::OP_RESTART: begin
                keep = 1'b1;
                kind = htbd_pkg::CMD_RESTART;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_push.push             = i_in_valid && !i_full && keep;
        o_push.beat.kind        = kind;
        o_push.beat.node_index  = i_node_index;
        o_push.beat.left_child  = i_left_child;
        o_push.beat.right_child = i_right_child;
        o_push.beat.has_left    = i_has_left;
        o_push.beat.has_right   = i_has_right;
        o_push.beat.leaf_symbol = i_leaf_symbol;
        o_push.beat.coded_bit   = i_coded_bit;
    end

endmodule

@@ rtl/htbd_queue.sv @@
// Short command queue between the front end and the tree walker.
module htbd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htbd_pkg::t_push   i_push,
    input  logic              i_pop,
    output htbd_pkg::t_q_head o_head,
    output logic              o_full
);

    localparam int PW = (htbd_pkg::QUEUE_DEPTH > 1) ? $clog2(htbd_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(htbd_pkg::QUEUE_DEPTH + 1);

    htbd_pkg::t_cmd_beat r_slot [htbd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(htbd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full       = (r_count == CW'(htbd_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.beat  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push.push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wr_ptr] <= i_push.beat;
        end
    end

endmodule

@@ rtl/htbd_back.sv @@
// Back end: node table, tree walker and result register.
module htbd_back #(
    parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
    parameter int SYMBOL_BITS = htbd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [htbd_pkg::IDX_W-1:0]     i_root,
    input  htbd_pkg::t_q_head              i_head,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [htbd_pkg::SYM_OUT_W-1:0] o_symbol,
    output logic                           o_symbol_valid,
    output logic                           o_walk_error
);

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef struct packed {
        logic [htbd_pkg::IDX_W-1:0] left;
        logic [htbd_pkg::IDX_W-1:0] right;
        logic                       has_left;
        logic                       has_right;
        logic [SYMBOL_BITS-1:0]     sym;
    } t_node;

    t_node r_mem [NODE_COUNT];
    t_node r_rd_data;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    t_node         wr_data;

    htbd_pkg::t_back_state r_state, n_state;
    logic [htbd_pkg::IDX_W-1:0]   r_cur, n_cur;
    logic                         r_cur_valid, n_cur_valid;
    t_node                        r_cur_entry, n_cur_entry;
    logic                         r_out_valid, n_out_valid;
    logic [htbd_pkg::SYM_OUT_W-1:0] r_out_sym, n_out_sym;
    logic                         r_out_err, n_out_err;

    htbd_pkg::t_cmd_beat        head;
    logic                       step_present, step_ok, out_free, leaf, cur_in_range;
    logic [htbd_pkg::IDX_W-1:0] step_next;

    // node table, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign head         = i_head.beat;
    assign step_present = head.coded_bit ? r_cur_entry.has_right : r_cur_entry.has_left;
    assign step_next    = head.coded_bit ? r_cur_entry.right : r_cur_entry.left;
    assign step_ok      = step_present && (32'(step_next) < NODE_COUNT);
    assign out_free     = !r_out_valid || i_out_ready;
    assign leaf         = !r_rd_data.has_left && !r_rd_data.has_right;
    assign cur_in_range = (32'(r_cur) < NODE_COUNT);

    always_comb begin
        wr_en            = 1'b0;
        wr_addr          = AW'(head.node_index);
        wr_data.left      = head.left_child;
        wr_data.right     = head.right_child;
        wr_data.has_left  = head.has_left;
        wr_data.has_right = head.has_right;
        wr_data.sym       = SYMBOL_BITS'(head.leaf_symbol);
        rd_en       = 1'b0;
        rd_addr     = AW'(r_cur);
        o_pop       = 1'b0;
        n_state     = r_state;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_cur_entry = r_cur_entry;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_sym   = r_out_sym;
        n_out_err   = r_out_err;

        case (r_state)
            htbd_pkg::B_IDLE: begin
                if (i_head.valid) begin
                    case (head.kind)
                        htbd_pkg::CMD_WRITE: begin
                            wr_en = 1'b1;
                            o_pop = 1'b1;
                            // cached copy of the current node goes stale
                            if (head.node_index == r_cur) begin
                                n_cur_valid = 1'b0;
                            end
                        end
                        htbd_pkg::CMD_RESTART: begin
                            o_pop       = 1'b1;
                            n_cur       = i_root;
                            n_cur_valid = 1'b0;
                        end
                        htbd_pkg::CMD_BIT: begin
                            if (!r_cur_valid) begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(r_cur);
                                n_state = htbd_pkg::B_CUR;
                            end else if (!step_ok) begin
                                if (out_free) begin
                                    o_pop       = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_out_sym   = '0;
                                    n_out_err   = 1'b1;
                                    n_cur       = i_root;
                                    n_cur_valid = 1'b0;
                                end
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(step_next);
                                n_state = htbd_pkg::B_NEXT;
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            htbd_pkg::B_CUR: begin
                // off-table node reads as an empty entry
                n_cur_entry = cur_in_range ? r_rd_data : '0;
                n_cur_valid = 1'b1;
                n_state     = htbd_pkg::B_IDLE;
            end
            htbd_pkg::B_NEXT: begin
                if (leaf) begin
                    if (out_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_sym   = htbd_pkg::SYM_OUT_W'(r_rd_data.sym);
                        n_out_err   = 1'b0;
                        n_cur       = i_root;
                        n_cur_valid = 1'b0;
                        n_state     = htbd_pkg::B_IDLE;
                    end
                end else begin
                    o_pop       = 1'b1;
                    n_cur       = step_next;
                    n_cur_entry = r_rd_data;
                    n_cur_valid = 1'b1;
                    n_state     = htbd_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = htbd_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htbd_pkg::B_IDLE;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_entry <= n_cur_entry;
        r_out_sym   <= n_out_sym;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_symbol_valid = !r_out_err;
    assign o_walk_error   = r_out_err;

endmodule

@@ rtl/huffman_tree_bit_decoder.sv @@
// Top level of the bit-serial code tree walk decoder.
//
// Input channel (i_in_valid / o_in_ready) takes one beat per command: write a
// node entry, decode one coded bit, or restart the walk at the root. Code 3
// is accepted and dropped, as are writes to entries beyond the table.
// Output channel (o_out_valid / i_out_ready) carries one beat for each bit
// that ends a walk: a decoded symbol, or a walk error for a missing or off-table child.
// i_cfg_we / i_cfg_data load the root register; write only while idle. The
// root takes effect at the next restart or at the end of a walk.
// Processing: a bit that continues a walk from a cached node reads the child
// from the registered node table (B_IDLE, then B_NEXT); the first bit after a
// restart, a finished walk, or a write to the current node first fetches the
// current node (B_CUR) and then the child. A bit that hits a missing child
// ends without the child read. Writes and restarts are handled in B_IDLE.
// A 2-deep command queue lets input beats be accepted while the walker waits.
// When the receiver stalls the result register holds; the walker stops at the
// next bit that would produce a result, and input backs up once the queue is
// full. Reset clears the walk to node 0, the root to 0 and all handshakes; the
// node table is not cleared and must be written before it is walked.
`include "assert_macros.svh"

module huffman_tree_bit_decoder #(
    parameter int NODE_COUNT  = htbd_pkg::NODE_COUNT_DEF,
    parameter int SYMBOL_BITS = htbd_pkg::SYMBOL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [htbd_pkg::IDX_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_operation,
    input  logic [htbd_pkg::IDX_W-1:0]     i_node_index,
    input  logic [htbd_pkg::IDX_W-1:0]     i_left_child,
    input  logic [htbd_pkg::IDX_W-1:0]     i_right_child,
    input  logic                           i_has_left,
    input  logic                           i_has_right,
    input  logic [htbd_pkg::SYM_IN_W-1:0]  i_leaf_symbol,
    input  logic                           i_coded_bit,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [htbd_pkg::SYM_OUT_W-1:0] o_symbol,
    output logic                           o_symbol_valid,
    output logic                           o_walk_error
);

    logic [htbd_pkg::IDX_W-1:0] r_root;
    htbd_pkg::t_push            push;
    htbd_pkg::t_q_head          head;
    logic                       pop;
    logic                       full;

    // root register, plain write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_data;
        end
    end

    htbd_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_full        (full),
        .i_operation   (i_operation),
        .i_node_index  (i_node_index),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_has_left    (i_has_left),
        .i_has_right   (i_has_right),
        .i_leaf_symbol (i_leaf_symbol),
        .i_coded_bit   (i_coded_bit),
        .o_push        (push)
    );

    htbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    htbd_back #(
        .NODE_COUNT  (NODE_COUNT),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_root         (r_root),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_symbol_valid (o_symbol_valid),
        .o_walk_error   (o_walk_error)
    );

    // walker never pops an empty queue
    `HTBD_ASSERT_IMP(a_pop_has_head, i_clk, i_rst_n, pop, head.valid)
    // front never pushes into a full queue
    `HTBD_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, push.push && full)
    // an error beat carries no symbol
    `HTBD_ASSERT_IMP(a_err_no_sym, i_clk, i_rst_n, o_out_valid && o_walk_error, o_symbol == '0)

endmodule
